[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with the clock and reset names fixed for this project.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

[rtl/cht_pkg.sv]
`timescale 1ns / 1ps

package cht_pkg;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_REJECTED  = 3'd5;
    localparam logic [2:0] ST_POOL_FULL = 3'd6;

    localparam int KEY_BITS      = 15;
    localparam int CFG_RESET     = 16;
    localparam int DIV_STEPS     = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_HEAD,
        S_CHK,
        S_DONE
    } t_state;

endpackage

[rtl/chained_hash_table_core.sv]
`timescale 1ns / 1ps
// A transaction runs the 16 hash steps in a one-bit restoring divider, the head read, the
// decision and the output load when only the bucket head is touched, plus one step per
// chain node walked; a rejected key goes from the head read straight to the output load.
// One transaction is in flight at a time; a new item is taken the cycle after its result
// enters the output register. Synchronous active-low reset empties every bucket, refills
// the node pool and sets the bucket count to 16.

module chained_hash_table_core
    import cht_pkg::*;
#(
    parameter int BUCKETS    = 64,
    parameter int NODES      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // operation[1:0], key[17:2], value[49:18], zero
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[2:0], found_value[34:3], bucket[40:35], zero
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = NW + 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(NODES);
    localparam int CW = $clog2(DIV_STEPS);

    // Storage
    logic [LW-1:0]         m_head  [BUCKETS];
    logic [KEY_BITS-1:0]   m_key   [NODES];
    logic [VALUE_BITS-1:0] m_val   [NODES];
    logic [LW-1:0]         m_next  [NODES];
    logic [NW-1:0]         m_stack [NODES];

    t_state r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [7:0]            r_rem, n_rem;
    logic [1:0]            r_op;
    logic [15:0]           r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [NW-1:0]         r_cur, n_cur;
    logic [LW-1:0]         r_prev, n_prev;
    logic [NW-1:0]         r_new, n_new;
    logic [LW-1:0]         r_fresh, n_fresh;
    logic [LW-1:0]         r_rcnt, n_rcnt;
    logic [6:0]            r_cfg;
    logic [BUCKETS-1:0]    r_head_vld;
    logic [2:0]            r_status, n_status;
    logic [31:0]           r_found, n_found;
    logic                  r_out_valid;
    logic [47:0]           r_out_data;

    logic [LW-1:0]         r_head_q;
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;
    logic [LW-1:0]         r_next_q;
    logic [NW-1:0]         r_stack_q;

    logic                  w_accept;
    logic [7:0]            w_div;
    logic [7:0]            w_shift;
    logic [BW-1:0]         w_bidx;
    logic [LW-1:0]         w_head_link;
    logic                  w_head_null;
    logic                  w_next_null;
    logic                  w_key_hit;
    logic                  w_pool_full;
    logic                  w_reject;
    logic [NW-1:0]         w_alloc;
    logic                  w_out_free;

    logic                  w_head_we;
    logic [LW-1:0]         w_head_wd;
    logic                  w_node_we;
    logic                  w_next_we;
    logic [NW-1:0]         w_next_wa;
    logic [LW-1:0]         w_next_wd;
    logic                  w_stack_we;

    // Shared signals
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_bidx      = BW'(r_rem);
    assign w_head_link = r_head_vld[w_bidx] ? r_head_q : NULL_LINK;
    assign w_head_null = (w_head_link >= NULL_LINK);
    assign w_next_null = (r_next_q >= NULL_LINK);
    assign w_key_hit   = (r_key_q == r_key[KEY_BITS-1:0]);
    assign w_pool_full = (r_fresh == NULL_LINK) && (r_rcnt == '0);
    assign w_reject    = r_key[15] || (r_op != OP_INSERT && r_op != OP_FIND
                                       && r_op != OP_DELETE);
    assign w_alloc     = (r_rcnt != '0) ? r_stack_q : NW'(r_fresh);
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_shift     = {r_rem[6:0], r_key[r_cnt]};

    // Effective divisor: zero reads as one, saturate at the bucket count
    always_comb begin
        if (r_cfg == '0) begin
            w_div = 8'd1;
        end else if (32'(r_cfg) > BUCKETS) begin
            w_div = 8'(BUCKETS);
        end else begin
            w_div = {1'b0, r_cfg};
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_RD;
            end
            S_RD: begin
                n_state = w_reject ? S_DONE : S_HEAD;
            end
            S_HEAD: begin
                if (r_op == OP_INSERT) begin
                    n_state = (w_pool_full || w_head_null) ? S_DONE : S_CHK;
                end else begin
                    n_state = w_head_null ? S_DONE : S_CHK;
                end
            end
            S_CHK: begin
                if (r_op == OP_INSERT) begin
                    if (w_next_null) n_state = S_DONE;
                end else if (w_key_hit || w_next_null) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_new      = r_new;
        n_fresh    = r_fresh;
        n_rcnt     = r_rcnt;
        n_status   = r_status;
        n_found    = r_found;
        w_head_we  = 1'b0;
        w_head_wd  = r_next_q;
        w_node_we  = 1'b0;
        w_next_we  = 1'b0;
        w_next_wa  = r_cur;
        w_next_wd  = NULL_LINK;
        w_stack_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_cnt   = CW'(DIV_STEPS - 1);
                n_rem   = '0;
                n_found = '0;
            end
            S_DIV: begin
                // one quotient bit a cycle, remainder kept
                n_rem = (w_shift >= w_div) ? (w_shift - w_div) : w_shift;
                n_cnt = r_cnt - 1'b1;
            end
            S_RD: begin
                n_status = ST_REJECTED;
            end
            S_HEAD: begin
                if (r_op == OP_INSERT) begin
                    if (w_pool_full) begin
                        n_status = ST_POOL_FULL;
                    end else begin
                        n_new     = w_alloc;
                        w_node_we = 1'b1;
                        w_next_we = 1'b1;
                        w_next_wa = w_alloc;
                        w_next_wd = NULL_LINK;
                        if (r_rcnt != '0) n_rcnt = r_rcnt - 1'b1;
                        else              n_fresh = r_fresh + 1'b1;
                        n_status = ST_INSERTED;
                        if (w_head_null) begin
                            w_head_we = 1'b1;
                            w_head_wd = {1'b0, w_alloc};
                        end else begin
                            n_cur = NW'(w_head_link);
                        end
                    end
                end else begin
                    n_prev = NULL_LINK;
                    n_cur  = NW'(w_head_link);
                    if (w_head_null) begin
                        n_status = (r_op == OP_DELETE) ? ST_EMPTY : ST_NOT_FOUND;
                    end
                end
            end
            S_CHK: begin
                if (r_op == OP_INSERT) begin
                    // walk to the tail, then link the new node
                    if (w_next_null) begin
                        w_next_we = 1'b1;
                        w_next_wa = r_cur;
                        w_next_wd = {1'b0, r_new};
                    end else begin
                        n_cur = NW'(r_next_q);
                    end
                end else if (w_key_hit) begin
                    n_found = 32'(r_val_q);
                    if (r_op == OP_FIND) begin
                        n_status = ST_FOUND;
                    end else begin
                        n_status = ST_DELETED;
                        if (r_prev >= NULL_LINK) begin
                            w_head_we = 1'b1;
                            w_head_wd = r_next_q;
                        end else begin
                            w_next_we = 1'b1;
                            w_next_wa = NW'(r_prev);
                            w_next_wd = r_next_q;
                        end
                        w_stack_we = 1'b1;
                        n_rcnt     = r_rcnt + 1'b1;
                    end
                end else if (w_next_null) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_prev = {1'b0, r_cur};
                    n_cur  = NW'(r_next_q);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fresh     <= '0;
            r_rcnt      <= '0;
            r_cfg       <= 7'(CFG_RESET);
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_rcnt  <= n_rcnt;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (w_head_we) r_head_vld[w_bidx] <= 1'b1;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_new    <= n_new;
        r_status <= n_status;
        r_found  <= n_found;
        if (w_accept) begin
            r_op  <= s_axis_tdata[1:0];
            r_key <= s_axis_tdata[17:2];
            r_val <= VALUE_BITS'(s_axis_tdata[49:18]);
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= {7'd0, r_rem[5:0], r_found, r_status};
        end
    end

    // Bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_head_we) m_head[w_bidx] <= w_head_wd;
        r_head_q <= m_head[w_bidx];
    end

    // Node memories, read at the next walk position
    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            m_key[w_alloc] <= r_key[KEY_BITS-1:0];
            m_val[w_alloc] <= r_val;
        end
        if (w_next_we) m_next[w_next_wa] <= w_next_wd;
        r_key_q  <= m_key[n_cur];
        r_val_q  <= m_val[n_cur];
        r_next_q <= m_next[n_cur];
    end

    // Recycled node stack, top entry read ahead
    always_ff @(posedge i_clk) begin
        if (w_stack_we) m_stack[NW'(r_rcnt)] <= r_cur;
        r_stack_q <= m_stack[NW'(r_rcnt - 1'b1)];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[rtl/cht_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cht_checker
    import cht_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    logic w_tag_ok;

    // A tag is reported only on a hit
    assign w_tag_ok = (m_axis_tdata[2:0] == ST_FOUND) || (m_axis_tdata[2:0] == ST_DELETED)
                      || (m_axis_tdata[34:3] == 32'd0);

    // A stalled result stays offered
    `ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

    // Status is always a defined code
    `ASSERT_STD(a_status_code, m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7, "bad status")

    // Tag only on a hit
    `ASSERT_STD(a_found_zero, m_axis_tvalid |-> w_tag_ok, "tag on miss")

    // One transaction in flight: busy right after taking an item
    `ASSERT_STD(a_busy_after, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready while busy")

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import cht_pkg::*;

    localparam int NBKT = 64;
    localparam int NNODE = 256;
    localparam int WATCHDOG = 20000;
    localparam logic [1:0] OP_BAD = 2'd3;

    // Field order matches the result tdata, lowest bits last
    typedef struct packed {
        logic [5:0]  bucket;
        logic [31:0] found_value;
        logic [2:0]  status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    chained_hash_table_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow table: per-bucket chains of (key, tag), oldest first
    logic [14:0] chain_key [NBKT][$];
    logic [31:0] chain_tag [NBKT][$];
    int          nodes_used;
    logic [6:0]  bucket_reg;
    t_result     pending_results[$];
    int          fail_count;
    int          idle_cycles;
    bit          no_idle;
    logic [14:0] live_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int eff_buckets();
        if (bucket_reg == 0) return 1;
        if (bucket_reg > NBKT) return NBKT;
        return bucket_reg;
    endfunction

    // Predict one operation's result and update the shadow table
    function automatic t_result table_lookup(logic [1:0] op, logic [15:0] key,
                                             logic [31:0] tag);
        t_result r;
        int b;
        int hit;
        b = key % eff_buckets();
        r.status = ST_REJECTED;
        r.found_value = '0;
        r.bucket = b[5:0];
        if (key > 16'd32767) return r;
        hit = -1;
        for (int i = 0; i < chain_key[b].size(); i++) begin
            if (hit < 0 && chain_key[b][i] == key[14:0]) hit = i;
        end
        case (op)
            OP_INSERT: begin
                if (nodes_used >= NNODE) begin
                    r.status = ST_POOL_FULL;
                end else begin
                    chain_key[b].push_back(key[14:0]);
                    chain_tag[b].push_back(tag);
                    nodes_used++;
                    r.status = ST_INSERTED;
                end
            end
            OP_FIND: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.status = ST_FOUND;
                    r.found_value = chain_tag[b][hit];
                end
            end
            OP_DELETE: begin
                if (chain_key[b].size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.status = ST_DELETED;
                    r.found_value = chain_tag[b][hit];
                    chain_key[b].delete(hit);
                    chain_tag[b].delete(hit);
                    nodes_used--;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one operation, predicting at acceptance; tvalid is dropped by idling or drain
    task automatic send_op(logic [1:0] op, logic [15:0] key, logic [31:0] tag);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {6'd0, tag, key, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(table_lookup(op, key, tag));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_buckets(logic [6:0] n);
        drain();
        // chains are rebuilt under the new hash, so empty the table first
        for (int b = 0; b < NBKT; b++) begin
            while (chain_key[b].size() != 0)
                send_op(OP_DELETE, {1'b0, chain_key[b][0]}, '0);
        end
        drain();
        i_cfg_wdata <= n;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        bucket_reg = n;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[40:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.found_value !== want.found_value) begin
                    $error("found_value exp %h got %h", want.found_value, got.found_value);
                    fail_count++;
                end
                if (got.bucket !== want.bucket) begin
                    $error("bucket exp %0d got %0d", want.bucket, got.bucket);
                    fail_count++;
                end
            end
        end
    end

    // Output backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(OP_FIND, 16'd5, '0);
        send_op(OP_DELETE, 16'd5, '0);
        send_op(OP_INSERT, 16'd5, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 16'd21, 32'h0000_0001);
        send_op(OP_INSERT, 16'd5, 32'hA5A5_5A5A);
        send_op(OP_FIND, 16'd5, '0);
        send_op(OP_FIND, 16'd37, '0);
        send_op(OP_DELETE, 16'd37, '0);
        send_op(OP_DELETE, 16'd5, '0);
        send_op(OP_FIND, 16'd5, '0);
        send_op(OP_INSERT, 16'd32767, 32'h0);
        send_op(OP_FIND, 16'd32767, '0);
        send_op(OP_INSERT, 16'd32768, 32'h1234);
        send_op(OP_FIND, 16'hFFFF, '0);
        send_op(OP_BAD, 16'd21, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 16'd0, '0);
        send_op(OP_INSERT, 16'd0, 32'h5555_AAAA);
        send_op(OP_DELETE, 16'd0, 32'hFFFF_FFFF);
    endtask

    // Fill the pool to overflow
    task automatic test_pool_full();
        for (int i = 0; i < NNODE + 3; i++)
            send_op(OP_INSERT, 16'($urandom_range(200)), $urandom);
        send_op(OP_FIND, 16'd7, '0);
    endtask

    task automatic test_random(int count, logic [15:0] key_span);
        logic [1:0]  op;
        logic [15:0] key;
        for (int i = 0; i < count; i++) begin
            op = 2'($urandom_range(2));
            key = 16'($urandom_range(key_span));
            if ($urandom_range(99) < 8) begin
                op = 2'($urandom_range(3));
                key = 16'($urandom);
            end else if (op != OP_INSERT && live_keys.size() != 0 && $urandom_range(3) != 0) begin
                key = {1'b0, live_keys[$urandom_range(live_keys.size() - 1)]};
            end
            if (op == OP_INSERT) live_keys.push_back(key[14:0]);
            if (nodes_used > 200 && op == OP_INSERT) op = OP_DELETE;
            send_op(op, key, $urandom);
        end
    endtask

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        nodes_used = 0;
        bucket_reg = 7'd16;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(40, 16'd32767);
        write_buckets(7'd1);
        test_random(30, 16'd300);
        write_buckets(7'd127);
        test_random(40, 16'd2000);
        write_buckets(7'd64);
        no_idle = 1'b1;
        test_random(40, 16'd500);
        no_idle = 1'b0;
        write_buckets(7'd13);
        test_random(40, 16'd100);
        write_buckets(7'd0);
        test_pool_full();
        drain();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
